[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Types and constants shared by the priority scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

    localparam int MAX_PROCESSES_DEF = 16;

    // result status codes
    localparam logic [2:0] STAT_LOADED = 3'd0;
    localparam logic [2:0] STAT_FULL   = 3'd1;
    localparam logic [2:0] STAT_RAN    = 3'd2;
    localparam logic [2:0] STAT_IDLE   = 3'd3;
    localparam logic [2:0] STAT_DONE   = 3'd4;

    // action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [15:0] ident;
        logic [15:0] arrival;
        logic [15:0] remaining;
        logic [7:0]  urgency;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // load transfer accepted this cycle
        logic tick_start;  // tick transfer accepted this cycle
        logic issue;       // read table entry at scan index
        logic finish;      // commit tick result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;       // table holds no entries
        logic last;        // scan index points at the last entry
    } sts_t;

endpackage

`default_nettype wire

[rtl/core/pps_ctrl.sv]
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer for the scheduler: accepts commands and steps the table scan.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pps_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          action,
    input  wire pps_pkg::sts_t sts,
    output pps_pkg::cmd_t      cmd,
    output logic               busy
);

    import pps_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load       = accept && (action == ACT_LOAD);
                cmd.tick_start = accept && (action == ACT_TICK);
                if (cmd.tick_start)
                begin
                    state_next = sts.empty ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            // last read data is evaluated here
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_ALWAYS(a_one_cmd, $countones(cmd) <= 1, "more than one datapath command")
    `ASSERT_NEXT(a_finish_idle, cmd.finish, state_reg == ST_IDLE, "no return to idle")
    `ASSERT_NEXT(a_tick_busy, cmd.tick_start, busy, "tick accepted but not busy")

endmodule

`default_nettype wire

[rtl/core/pps_dpath.sv]
// ----------------------------------------------------------------------------
// pps_dpath
// Job table, scan comparator, time counter and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pps_dpath #(
    parameter int MAX_PROCESSES = pps_pkg::MAX_PROCESSES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pps_pkg::cmd_t cmd,
    output pps_pkg::sts_t      sts,
    input  wire logic [15:0]   job_id,
    input  wire logic [15:0]   arrival,
    input  wire logic [15:0]   burst,
    input  wire logic [7:0]    urgency,
    output logic               valid,
    output logic [2:0]         status,
    output logic [31:0]        tick_time,
    output logic [15:0]        running_id,
    output logic               finished
);

    import pps_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCESSES);

    entry_t mem [MAX_PROCESSES];

    logic [CNT_W-1:0] count_reg;
    logic [31:0]      now_time_reg;
    logic [IDX_W-1:0] scan_idx_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    entry_t           rd_data_reg;
    logic             pending_reg;
    logic             found_reg;
    logic [IDX_W-1:0] pick_idx_reg;
    entry_t           best_reg;

    logic             valid_reg;
    logic [2:0]       status_reg;
    logic [31:0]      tick_time_reg;
    logic [15:0]      running_id_reg;
    logic             finished_reg;

    logic             full;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             ready_hit;
    logic             better;
    logic [31:0]      time_inc;

    assign full      = (count_reg >= CNT_MAX);
    assign sts.empty = (count_reg == '0);
    assign sts.last  = (CNT_W'(scan_idx_reg) == CNT_W'(count_reg - 1'b1));

    assign time_inc = (now_time_reg == 32'hFFFF_FFFF) ? now_time_reg : now_time_reg + 32'd1;

    // entry is ready when it has work left and has arrived
    assign ready_hit = rd_vld_reg && (rd_data_reg.remaining != 16'd0)
                       && ({16'd0, rd_data_reg.arrival} <= now_time_reg);
    // strict compare keeps the earliest loaded job on ties
    assign better    = !found_reg || (rd_data_reg.urgency < best_reg.urgency);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pick_idx_reg;
        wr_data = best_reg;
        wr_data.remaining = best_reg.remaining - 16'd1;
        if (cmd.load)
        begin
            wr_en   = !full;
            wr_addr = count_reg[IDX_W-1:0];
            wr_data = '{ident: job_id, arrival: arrival, remaining: burst, urgency: urgency};
        end
        else if (cmd.finish)
        begin
            wr_en = found_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_idx_reg <= scan_idx_reg;
        end
        if (ready_hit && better)
        begin
            best_reg     <= rd_data_reg;
            pick_idx_reg <= rd_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            now_time_reg <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            pending_reg  <= 1'b0;
            found_reg    <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.issue;
            valid_reg  <= cmd.load || cmd.finish;
            if (cmd.load && !full)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.tick_start)
            begin
                scan_idx_reg <= '0;
                pending_reg  <= 1'b0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (rd_vld_reg && (rd_data_reg.remaining != 16'd0))
                begin
                    pending_reg <= 1'b1;
                end
                if (ready_hit)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.finish && pending_reg)
            begin
                now_time_reg <= time_inc;
            end
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg     <= full ? STAT_FULL : STAT_LOADED;
            tick_time_reg  <= '0;
            running_id_reg <= '0;
            finished_reg   <= 1'b0;
        end
        else if (cmd.finish)
        begin
            tick_time_reg  <= now_time_reg;
            running_id_reg <= '0;
            finished_reg   <= 1'b0;
            priority if (!pending_reg)
            begin
                status_reg <= STAT_DONE;
            end
            else if (!found_reg)
            begin
                status_reg <= STAT_IDLE;
            end
            else
            begin
                status_reg     <= STAT_RAN;
                running_id_reg <= best_reg.ident;
                finished_reg   <= (best_reg.remaining == 16'd1);
            end
        end
    end

    assign valid      = valid_reg;
    assign status     = status_reg;
    assign tick_time  = tick_time_reg;
    assign running_id = running_id_reg;
    assign finished   = finished_reg;

    `ASSERT_ALWAYS(a_count_max, count_reg <= CNT_MAX, "entry count past table size")
    `ASSERT_ALWAYS(a_found_pending, !found_reg || pending_reg, "ready job without pending work")
    `ASSERT_ALWAYS(a_time_mono, now_time_reg >= $past(now_time_reg), "time counter went back")
    `ASSERT_NEXT(a_load_result, cmd.load, valid_reg, "load gave no result")

endmodule

`default_nettype wire

[rtl/core/preemptive_priority_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Priority scheduler: loads jobs into a table and runs one unit per tick.
// ----------------------------------------------------------------------------
//
//  channel   handshake        fields
//  -------   --------------   ---------------------------------------------
//  command   start / busy     action, job_id, arrival, burst, urgency
//  result    valid (strobe)   status, tick_time, running_id, finished
//
//  A load completes at the transfer edge; its result shows the next cycle.
//  A tick keeps busy high through a scan state with one table read per entry
//  through the single memory read port, a drain state and a commit state,
//  or through the commit state alone on an empty table; the result strobes
//  in the first cycle with busy low again.
//  Reset clears the entry count, time and control; no table clearing pass.
//  Results are shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module preemptive_priority_scheduler_unit #(
    parameter int MAX_PROCESSES = pps_pkg::MAX_PROCESSES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        action,
    input  wire logic [15:0] job_id,
    input  wire logic [15:0] arrival,
    input  wire logic [15:0] burst,
    input  wire logic [7:0]  urgency,
    output logic             valid,
    output logic [2:0]       status,
    output logic [31:0]      tick_time,
    output logic [15:0]      running_id,
    output logic             finished
);

    import pps_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    pps_dpath #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .job_id     (job_id),
        .arrival    (arrival),
        .burst      (burst),
        .urgency    (urgency),
        .valid      (valid),
        .status     (status),
        .tick_time  (tick_time),
        .running_id (running_id),
        .finished   (finished)
    );

endmodule

`default_nettype wire
